// File: hw/rtl/rbf_adaptive_torque_control_defines.svh
// Assertion macros shared by the RBF torque controller RTL.
`ifndef RBF_ADAPTIVE_TORQUE_CONTROL_DEFINES_SVH
`define RBF_ADAPTIVE_TORQUE_CONTROL_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define RBF_ATC_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rbf_atc check failed");

// Condition implies consequence in the following cycle.
`define RBF_ATC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rbf_atc check failed");

`endif

// File: hw/rtl/rbf_atc_pkg.sv
// Types, constants and helpers of the RBF torque controller.
package rbf_atc_pkg;

    typedef struct packed {
        logic signed [31:0] error;
        logic signed [31:0] error_rate;
        logic signed [31:0] ref_accel;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] torque;
        logic signed [31:0] net_output;
    } result_t;

    // configuration register indexes
    localparam logic [2:0] REG_POS_GAIN      = 3'd0;
    localparam logic [2:0] REG_VEL_GAIN      = 3'd1;
    localparam logic [2:0] REG_TORQUE_SCALE  = 3'd2;
    localparam logic [2:0] REG_ADAPT_GAIN    = 3'd3;
    localparam logic [2:0] REG_LEAK_GAIN     = 3'd4;
    localparam logic [2:0] REG_ERR_COEF      = 3'd5;
    localparam logic [2:0] REG_RATE_COEF     = 3'd6;
    localparam logic [2:0] REG_INV_TWO_WIDTH = 3'd7;

    localparam int WEIGHT_W = 32;
    localparam int HIDDEN_W = 17;
    localparam int WORD_W   = WEIGHT_W + HIDDEN_W;

    localparam int CENTRE_PAIRS = 9;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    localparam logic signed [31:0] CENTRES [18] = '{
        -32'sd196608, -32'sd196608, -32'sd131072, -32'sd131072,
        -32'sd98304,  -32'sd98304,  -32'sd65536,  -32'sd65536,
        32'sd0,       32'sd0,       32'sd65536,   32'sd65536,
        32'sd98304,   32'sd98304,   -32'sd131072, -32'sd131072,
        -32'sd196608, -32'sd196608
    };

    // 2^(-k/16), Q1.16
    localparam logic [16:0] POW2 [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/rbf_atc_if.sv
// Valid/ready stream interfaces for samples and results.
interface rbf_atc_sample_if;
    logic                 valid;
    logic                 ready;
    rbf_atc_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbf_atc_result_if;
    logic                 valid;
    logic                 ready;
    rbf_atc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/rbf_atc_ram.sv
// Generic single-port-write, registered-read RAM.
module rbf_atc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/rbf_atc_isqrt.sv
// Iterative 64-bit integer square root, two radicand bits per cycle.
module rbf_atc_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        busy,
    output logic [31:0] root
);

    logic        busy_reg;
    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= value;
            root_reg <= '0;
            bit_reg  <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg[31:0];

endmodule

// File: hw/rtl/rbf_adaptive_torque_control.sv
// Top level: RBF network adaptive torque controller, one sample per pass.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------
//  sample   | in  | valid/ready        | error, error_rate, ref_accel
//  result   | out | valid/ready        | torque, net_output
//  cfg      | in  | cfg_we (no stall)  | cfg_index, cfg_data
//
//  One request at a time. Front end time is set by the 32-step square root
//  of the error norm; each neuron runs through states S_N0 to S_N12 on the
//  single shared 34x34 multiplier and one read plus one write of the state
//  RAM. A finished result waits in the output register; a new sample is
//  taken meanwhile. Reset clears weights and hidden outputs through valid
//  bits.
`include "rbf_adaptive_torque_control_defines.svh"

module rbf_adaptive_torque_control #(
    parameter int NEURONS = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    rbf_atc_sample_if.sink           sample,
    rbf_atc_result_if.source         result,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_data
);

    localparam int IDX_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int SUM_W = 50 + IDX_W;

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ESQ  = 5'd1;
    localparam logic [4:0] S_DSQ  = 5'd2;
    localparam logic [4:0] S_SC1  = 5'd3;
    localparam logic [4:0] S_SC2  = 5'd4;
    localparam logic [4:0] S_TV   = 5'd5;
    localparam logic [4:0] S_TP   = 5'd6;
    localparam logic [4:0] S_TI   = 5'd7;
    localparam logic [4:0] S_TS   = 5'd8;
    localparam logic [4:0] S_TQ   = 5'd9;
    localparam logic [4:0] S_WAIT = 5'd10;
    localparam logic [4:0] S_LK   = 5'd11;
    localparam logic [4:0] S_N0   = 5'd12;
    localparam logic [4:0] S_N1   = 5'd13;
    localparam logic [4:0] S_N2   = 5'd14;
    localparam logic [4:0] S_N3   = 5'd15;
    localparam logic [4:0] S_N4   = 5'd16;
    localparam logic [4:0] S_N5   = 5'd17;
    localparam logic [4:0] S_N6   = 5'd18;
    localparam logic [4:0] S_N7   = 5'd19;
    localparam logic [4:0] S_N8   = 5'd20;
    localparam logic [4:0] S_N9   = 5'd21;
    localparam logic [4:0] S_N10  = 5'd22;
    localparam logic [4:0] S_N11  = 5'd23;
    localparam logic [4:0] S_N12  = 5'd24;
    localparam logic [4:0] S_FIN  = 5'd25;

    // configuration registers
    logic [30:0]        pos_gain_reg;
    logic [30:0]        vel_gain_reg;
    logic [30:0]        torque_scale_reg;
    logic [30:0]        adapt_gain_reg;
    logic signed [31:0] leak_gain_reg;
    logic signed [31:0] err_coef_reg;
    logic signed [31:0] rate_coef_reg;
    logic [30:0]        inv_two_width_reg;

    // control
    logic [4:0]         state_reg;
    logic [4:0]         state_next;
    logic [IDX_W-1:0]   nidx_reg;
    logic [3:0]         cidx_reg;
    logic [NEURONS-1:0] valid_reg;
    logic               out_valid_reg;
    logic               rd_valid_reg;

    // datapath
    logic signed [31:0] e_reg;
    logic signed [31:0] de_reg;
    logic signed [31:0] acc_reg;
    logic [63:0]        sqv_reg;
    logic signed [47:0] s_part_reg;
    logic signed [31:0] s_reg;
    logic signed [47:0] t1_reg;
    logic signed [31:0] inner_reg;
    logic signed [47:0] tq_part_reg;
    logic signed [31:0] b_reg;
    logic [31:0]        mx_reg;
    logic [31:0]        my_reg;
    logic signed [31:0] w_cur_reg;
    logic [16:0]        h_cur_reg;
    logic [48:0]        sq_reg;
    logic [32:0]        g_reg;
    logic [48:0]        dlo_reg;
    logic               far_reg;
    logic signed [48:0] a_reg;
    logic [19:0]        d_reg;
    logic               zero_reg;
    logic signed [31:0] w_new_reg;
    logic [4:0]         n_reg;
    logic [3:0]         k_reg;
    logic [16:0]        h_new_reg;
    logic signed [SUM_W-1:0] sum_reg;
    rbf_atc_pkg::result_t    out_reg;

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] prod_reg;
    logic signed [67:0] prod_sh;

    // RAM and root unit
    logic [rbf_atc_pkg::WORD_W-1:0] ram_rdata;
    logic                           ram_we;
    logic                           sqrt_busy;
    logic [31:0]                    sqrt_root;

    // combinational helpers
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [66:0]        dtotal;
    logic [3:0]         k_now;
    logic [11:0]        diff_now;
    logic [16:0]        v_lin;
    logic [17:0]        v_rnd;
    logic [16:0]        h_calc;
    logic signed [31:0] net_sat;
    logic signed [31:0] tq_sat;
    logic               accept;
    logic               out_load;
    logic               last_neuron;

    assign accept      = sample.valid && sample.ready;
    assign sample.ready = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;
    assign out_load     = (state_reg == S_FIN) && (!out_valid_reg || result.ready);
    assign ram_we       = (state_reg == S_N11);
    assign last_neuron  = (nidx_reg == IDX_W'(NEURONS - 1));
    assign prod_sh      = prod_reg >>> 16;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_gain_reg      <= 31'd262144;
            vel_gain_reg      <= 31'd262144;
            torque_scale_reg  <= 31'd655360;
            adapt_gain_reg    <= 31'd131072;
            leak_gain_reg     <= 32'sd131;
            err_coef_reg      <= 32'sd4096000;
            rate_coef_reg     <= 32'sd5120000;
            inv_two_width_reg <= 31'd6554;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbf_atc_pkg::REG_POS_GAIN:      pos_gain_reg      <= cfg_data[30:0];
                rbf_atc_pkg::REG_VEL_GAIN:      vel_gain_reg      <= cfg_data[30:0];
                rbf_atc_pkg::REG_TORQUE_SCALE:  torque_scale_reg  <= cfg_data[30:0];
                rbf_atc_pkg::REG_ADAPT_GAIN:    adapt_gain_reg    <= cfg_data[30:0];
                rbf_atc_pkg::REG_LEAK_GAIN:     leak_gain_reg     <= cfg_data;
                rbf_atc_pkg::REG_ERR_COEF:      err_coef_reg      <= cfg_data;
                rbf_atc_pkg::REG_RATE_COEF:     rate_coef_reg     <= cfg_data;
                rbf_atc_pkg::REG_INV_TWO_WIDTH: inv_two_width_reg <= cfg_data[30:0];
                default:                        ;
            endcase
        end
    end

    // multiplier operand select, one product per cycle
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ESQ:  begin mul_a = 34'(e_reg);  mul_b = 34'(e_reg);  end
            S_DSQ:  begin mul_a = 34'(de_reg); mul_b = 34'(de_reg); end
            S_SC1:  begin mul_a = 34'(err_coef_reg);  mul_b = 34'(e_reg);  end
            S_SC2:  begin mul_a = 34'(rate_coef_reg); mul_b = 34'(de_reg); end
            S_TV:   begin mul_a = 34'(vel_gain_reg);  mul_b = 34'(de_reg); end
            S_TP:   begin mul_a = 34'(pos_gain_reg);  mul_b = 34'(e_reg);  end
            S_TS:   begin mul_a = 34'(torque_scale_reg); mul_b = 34'(inner_reg); end
            S_WAIT: begin mul_a = 34'(leak_gain_reg); mul_b = 34'(sqrt_root); end
            S_N1:   begin mul_a = 34'(mx_reg); mul_b = 34'(mx_reg); end
            S_N2:   begin mul_a = 34'(my_reg); mul_b = 34'(my_reg); end
            S_N3:   begin mul_a = 34'(adapt_gain_reg); mul_b = 34'(h_cur_reg); end
            S_N4:   begin mul_a = 34'(sq_reg[17:0]);  mul_b = 34'(inv_two_width_reg); end
            S_N5:   begin mul_a = 34'(g_reg); mul_b = 34'(s_reg); end
            S_N6:   begin mul_a = 34'(sq_reg[35:18]); mul_b = 34'(inv_two_width_reg); end
            S_N7:   begin mul_a = 34'(b_reg); mul_b = 34'(w_cur_reg); end
            S_N8:   begin mul_a = 34'(d_reg); mul_b = 34'(rbf_atc_pkg::LOG2E_Q16); end
            S_N9:   begin mul_a = 34'(diff_now); mul_b = 34'(prod_reg[27:16]); end
            S_N11:  begin mul_a = 34'(h_new_reg); mul_b = 34'(w_new_reg); end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // distance to the current centre
    assign dx = 33'(e_reg)  - 33'(rbf_atc_pkg::CENTRES[{cidx_reg, 1'b0}]);
    assign dy = 33'(de_reg) - 33'(rbf_atc_pkg::CENTRES[{cidx_reg, 1'b1}]);

    // scaled distance from the two partial products
    assign dtotal = 67'(dlo_reg) + {prod_reg[48:0], 18'd0};

    // exp(-d) = 2^-y: table step and linear interpolation
    assign k_now    = prod_reg[31:28];
    assign diff_now = 12'(rbf_atc_pkg::POW2[5'(k_now)] - rbf_atc_pkg::POW2[5'(k_now) + 5'd1]);
    assign v_lin    = rbf_atc_pkg::POW2[5'(k_reg)]
                      - 17'((prod_reg[24:0] + 25'd2048) >> 12);
    assign v_rnd    = 18'(v_lin) + (18'd1 << (n_reg - 5'd1));

    always_comb
    begin
        if (zero_reg || n_reg >= 5'd17)
            h_calc = '0;
        else if (n_reg == 5'd0)
            h_calc = v_lin;
        else
            h_calc = 17'(v_rnd >> n_reg);
    end

    assign net_sat = rbf_atc_pkg::sat32(68'(sum_reg >>> 16));
    assign tq_sat  = rbf_atc_pkg::sat32(68'(tq_part_reg) - 68'(net_sat));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_ESQ;
            S_ESQ:  state_next = S_DSQ;
            S_DSQ:  state_next = S_SC1;
            S_SC1:  state_next = S_SC2;
            S_SC2:  state_next = S_TV;
            S_TV:   state_next = S_TP;
            S_TP:   state_next = S_TI;
            S_TI:   state_next = S_TS;
            S_TS:   state_next = S_TQ;
            S_TQ:   state_next = S_WAIT;
            S_WAIT: if (!sqrt_busy) state_next = S_LK;
            S_LK:   state_next = S_N0;
            S_N0:   state_next = S_N1;
            S_N1:   state_next = S_N2;
            S_N2:   state_next = S_N3;
            S_N3:   state_next = S_N4;
            S_N4:   state_next = S_N5;
            S_N5:   state_next = S_N6;
            S_N6:   state_next = S_N7;
            S_N7:   state_next = S_N8;
            S_N8:   state_next = S_N9;
            S_N9:   state_next = S_N10;
            S_N10:  state_next = S_N11;
            S_N11:  state_next = S_N12;
            S_N12:  state_next = last_neuron ? S_FIN : S_N0;
            S_FIN:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nidx_reg      <= '0;
            cidx_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LK)
            begin
                nidx_reg <= '0;
                cidx_reg <= '0;
            end
            else if (state_reg == S_N12 && !last_neuron)
            begin
                nidx_reg <= nidx_reg + 1'b1;
                cidx_reg <= (cidx_reg == 4'(rbf_atc_pkg::CENTRE_PAIRS - 1))
                            ? 4'd0 : cidx_reg + 4'd1;
            end
            if (ram_we)
            begin
                valid_reg[nidx_reg] <= 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    e_reg   <= sample.data.error;
                    de_reg  <= sample.data.error_rate;
                    acc_reg <= sample.data.ref_accel;
                end
            end
            S_DSQ:  sqv_reg    <= prod_reg[63:0];
            S_SC2:  s_part_reg <= prod_sh[47:0];
            S_TV:   s_reg      <= rbf_atc_pkg::sat32(68'(s_part_reg) + prod_sh);
            S_TP:   t1_reg     <= prod_sh[47:0];
            S_TI:   inner_reg  <= rbf_atc_pkg::sat32(68'(acc_reg) - 68'(t1_reg) - prod_sh);
            S_TQ:   tq_part_reg <= prod_sh[47:0];
            S_LK:
            begin
                b_reg   <= rbf_atc_pkg::sat32(prod_sh);
                sum_reg <= '0;
            end
            S_N0:
            begin
                rd_valid_reg <= valid_reg[nidx_reg];
                mx_reg <= dx[32] ? 32'(-dx) : 32'(dx);
                my_reg <= dy[32] ? 32'(-dy) : 32'(dy);
            end
            S_N1:
            begin
                // entries never written read as zero
                w_cur_reg <= rd_valid_reg ? ram_rdata[rbf_atc_pkg::WORD_W-1:rbf_atc_pkg::HIDDEN_W]
                                          : '0;
                h_cur_reg <= rd_valid_reg ? ram_rdata[rbf_atc_pkg::HIDDEN_W-1:0] : '0;
            end
            S_N2:   sq_reg <= 49'(prod_reg[63:16]);
            S_N3:   sq_reg <= sq_reg + 49'(prod_reg[63:16]);
            S_N4:
            begin
                g_reg   <= prod_reg[48:16];
                far_reg <= (sq_reg[48:36] != '0) && (inv_two_width_reg != '0);
            end
            S_N5:   dlo_reg <= prod_reg[48:0];
            S_N6:   a_reg   <= prod_sh[48:0];
            S_N7:
            begin
                d_reg    <= dtotal[35:16];
                zero_reg <= far_reg || (dtotal[66:36] != '0);
            end
            S_N8:   w_new_reg <= rbf_atc_pkg::sat32(68'(w_cur_reg) + 68'(a_reg) + prod_sh);
            S_N9:
            begin
                n_reg <= prod_reg[36:32];
                k_reg <= k_now;
            end
            S_N10:  h_new_reg <= h_calc;
            S_N12:  sum_reg <= sum_reg + SUM_W'(signed'(prod_reg[48:0]));
            S_FIN:
            begin
                if (out_load)
                begin
                    out_reg.torque     <= tq_sat;
                    out_reg.net_output <= net_sat;
                end
            end
            default: ;
        endcase
    end

    // weight and previous hidden output per neuron
    rbf_atc_ram #(
        .WIDTH (rbf_atc_pkg::WORD_W),
        .DEPTH (NEURONS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (nidx_reg),
        .wdata ({w_new_reg, h_new_reg}),
        .raddr (nidx_reg),
        .rdata (ram_rdata)
    );

    // error norm for the leakage term
    rbf_atc_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_SC1),
        .value (sqv_reg + prod_reg[63:0]),
        .busy  (sqrt_busy),
        .root  (sqrt_root)
    );

    `RBF_ATC_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != S_IDLE)
    `RBF_ATC_ASSERT_IMP(a_ram_index_range, ram_we, nidx_reg <= IDX_W'(NEURONS - 1))
    `RBF_ATC_ASSERT_IMP(a_root_ready_for_loop, state_reg == S_N0, !sqrt_busy)
    `RBF_ATC_ASSERT_IMP(a_centre_range, 1'b1, cidx_reg < 4'(rbf_atc_pkg::CENTRE_PAIRS))
    `RBF_ATC_ASSERT_NEXT(a_result_posted, out_load, out_valid_reg && state_reg == S_IDLE)

endmodule

// File: bench/tb.sv
// Self-checking bench for the RBF adaptive torque controller.
module tb;

    localparam int NEURONS = 9;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    rbf_atc_sample_if smp ();
    rbf_atc_result_if res ();

    rbf_adaptive_torque_control #(.NEURONS(NEURONS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp.sink),
        .result    (res.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Controller state as the bench sees it.
    longint kp, kv, tscale, adapt, inv_w;
    longint leak, ecoef, rcoef;
    longint wt [NEURONS];
    longint unsigned hid [NEURONS];

    rbf_atc_pkg::sample_t pend_samples [$];
    rbf_atc_pkg::result_t want_results [$];
    int errors;
    int send_gap_max;
    int recv_stall_max;
    int gap_left;
    int stall_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop; far beyond a slow but correct run.
    initial
    begin
        #60000000;
        $display("FAIL");
        $finish;
    end

    function automatic longint sat_word(longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // Exact floor square root, bit by bit.
    function automatic longint unsigned root_of(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Gaussian hidden output of one neuron, Q1.16.
    function automatic longint unsigned hidden_of(longint e, longint de, int idx);
        longint dx, dy;
        longint unsigned mx, my, sq, d, y, f, k, r, v, n, pk, pk1;
        int p;
        p  = (idx % rbf_atc_pkg::CENTRE_PAIRS) * 2;
        dx = e - longint'(rbf_atc_pkg::CENTRES[p]);
        dy = de - longint'(rbf_atc_pkg::CENTRES[p + 1]);
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        sq = ((mx * mx) >> 16) + ((my * my) >> 16);
        if (inv_w == 0)
            d = 0;
        else if (sq > 64'hFFFF_FFFF_FFFF_FFFF / longint'(inv_w))
            return 0;
        else
            d = (sq * longint'(inv_w)) >> 16;
        if (d >= (64'd16 << 16))
            return 0;
        y   = (d * 64'd94548) >> 16;
        n   = y >> 16;
        f   = y & 64'hFFFF;
        k   = f >> 12;
        r   = f & 64'hFFF;
        pk  = rbf_atc_pkg::POW2[k];
        pk1 = rbf_atc_pkg::POW2[k + 1];
        v   = pk - (((pk - pk1) * r + 64'd2048) >> 12);
        if (n == 0)
            return v;
        if (n >= 17)
            return 0;
        return (v + (64'd1 << (n - 1))) >> n;
    endfunction

    // Adapt weights, form new hidden outputs and queue the torque result.
    task automatic predict_torque(input rbf_atc_pkg::sample_t s);
        longint e, de, acc, sgn, lk, g, a, sum, net, inner, tq;
        longint unsigned nm;
        rbf_atc_pkg::result_t rr;
        e   = s.error;
        de  = s.error_rate;
        acc = s.ref_accel;
        sgn = sat_word(((ecoef * e) >>> 16) + ((rcoef * de) >>> 16));
        nm  = root_of(longint'(e * e) + longint'(de * de));
        lk  = sat_word((leak * longint'(nm)) >>> 16);
        for (int i = 0; i < NEURONS; i++)
        begin
            g     = longint'((longint'(adapt) * hid[i]) >> 16);
            a     = (g * sgn) >>> 16;
            wt[i] = sat_word(wt[i] + a + ((lk * wt[i]) >>> 16));
        end
        sum = 0;
        for (int i = 0; i < NEURONS; i++)
        begin
            hid[i] = hidden_of(e, de, i);
            sum    = sum + longint'(hid[i]) * wt[i];
        end
        net   = sat_word(sum >>> 16);
        inner = sat_word(acc - ((kv * de) >>> 16) - ((kp * e) >>> 16));
        tq    = sat_word(((tscale * inner) >>> 16) - net);
        rr.torque     = tq[31:0];
        rr.net_output = net[31:0];
        want_results.push_back(rr);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // One register write per clock; caller lowers cfg_we after the last.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            rbf_atc_pkg::REG_POS_GAIN:      kp     = val[30:0];
            rbf_atc_pkg::REG_VEL_GAIN:      kv     = val[30:0];
            rbf_atc_pkg::REG_TORQUE_SCALE:  tscale = val[30:0];
            rbf_atc_pkg::REG_ADAPT_GAIN:    adapt  = val[30:0];
            rbf_atc_pkg::REG_LEAK_GAIN:     leak   = longint'(signed'(val));
            rbf_atc_pkg::REG_ERR_COEF:      ecoef  = longint'(signed'(val));
            rbf_atc_pkg::REG_RATE_COEF:     rcoef  = longint'(signed'(val));
            rbf_atc_pkg::REG_INV_TWO_WIDTH: inv_w  = val[30:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_sample(input logic [31:0] e, input logic [31:0] de,
                              input logic [31:0] acc);
        rbf_atc_pkg::sample_t s;
        s.error      = e;
        s.error_rate = de;
        s.ref_accel  = acc;
        pend_samples.push_back(s);
    endtask

    // Mostly near the centres so the Gaussians and adaptation are active.
    function automatic logic [31:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return $urandom_range(0, 2 * 327680) - 327680;
        if (pick < 8)
            return $urandom_range(0, 2 * 4194304) - 4194304;
        return $urandom;
    endfunction

    // Checked at the falling edge, once the driver's updates have settled.
    task automatic wait_idle();
        while (pend_samples.size() != 0 || smp.valid || want_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic pick_pacing();
        send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 14;
        recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
    endtask

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
            add_sample(rand_coord(), rand_coord(), $urandom_range(0, 3) == 0 ?
                       $urandom : $urandom_range(0, 2 * 1310720) - 1310720);
        wait_idle();
    endtask

    // Sample driver: one request held until taken, random gap before the next.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp.valid <= 1'b0;
            smp.data  <= '0;
            gap_left  <= 0;
        end
        else
        begin
            if (smp.valid && smp.ready)
                predict_torque(smp.data);
            if (!smp.valid || smp.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    smp.valid <= 1'b0;
                end
                else if (pend_samples.size() != 0)
                begin
                    smp.data  <= pend_samples.pop_front();
                    smp.valid <= 1'b1;
                    gap_left  <= $urandom_range(0, send_gap_max);
                end
                else
                    smp.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        rbf_atc_pkg::result_t want;
        int n;
        if (!rst_n)
        begin
            res.ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (res.valid && res.ready)
        begin
            if (want_results.size() == 0)
                report("unexpected result", res.data.torque, 32'h0);
            else
            begin
                want = want_results.pop_front();
                if (res.data.torque !== want.torque)
                    report("torque", res.data.torque, want.torque);
                if (res.data.net_output !== want.net_output)
                    report("net_output", res.data.net_output, want.net_output);
            end
            n = $urandom_range(0, recv_stall_max);
            if (n > 0)
            begin
                res.ready  <= 1'b0;
                stall_left <= n;
            end
            else
                res.ready <= 1'b1;
        end
        else if (!res.ready)
        begin
            if (stall_left > 0)
                stall_left <= stall_left - 1;
            else
                res.ready <= 1'b1;
        end
    end

    initial
    begin
        errors         = 0;
        send_gap_max   = 14;
        recv_stall_max = 14;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        rst_n          = 1'b0;
        // Reset values of the controller registers and state.
        kp = 262144; kv = 262144; tscale = 655360; adapt = 131072;
        leak = 131; ecoef = 4096000; rcoef = 5120000; inv_w = 6554;
        for (int i = 0; i < NEURONS; i++)
        begin
            wt[i]  = 0;
            hid[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, each centre, far points, repeated samples
        // so the second one adapts from nonzero hidden outputs.
        add_sample(32'h0, 32'h0, 32'h0);
        add_sample(32'h0, 32'h0, 32'h0);
        add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555);
        add_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        for (int p = 0; p < rbf_atc_pkg::CENTRE_PAIRS; p++)
            add_sample(rbf_atc_pkg::CENTRES[2 * p], rbf_atc_pkg::CENTRES[2 * p + 1],
                       32'h0001_0000);
        add_sample(32'h0004_0000, 32'hFFFC_0000, 32'h0);
        add_sample(32'h0010_0000, 32'h0010_0000, 32'h0);
        add_sample(32'h0000_8000, 32'h0000_8000, 32'hFFFF_0000);
        wait_idle();

        // Zero width reciprocal: every hidden output becomes one.
        write_reg(rbf_atc_pkg::REG_INV_TWO_WIDTH, 32'h8000_0000);
        end_writes();
        add_sample(32'h0001_0000, 32'h0002_0000, 32'h0);
        add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        add_sample(32'h0001_0000, 32'h0002_0000, 32'h0);
        wait_idle();

        random_run(200);

        // Every register at its maximum, top bits set where they are ignored.
        pick_pacing();
        write_reg(rbf_atc_pkg::REG_POS_GAIN, 32'hFFFF_FFFF);
        write_reg(rbf_atc_pkg::REG_VEL_GAIN, 32'hFFFF_FFFF);
        write_reg(rbf_atc_pkg::REG_TORQUE_SCALE, 32'hFFFF_FFFF);
        write_reg(rbf_atc_pkg::REG_ADAPT_GAIN, 32'hFFFF_FFFF);
        write_reg(rbf_atc_pkg::REG_LEAK_GAIN, 32'h7FFF_FFFF);
        write_reg(rbf_atc_pkg::REG_ERR_COEF, 32'h7FFF_FFFF);
        write_reg(rbf_atc_pkg::REG_RATE_COEF, 32'h7FFF_FFFF);
        write_reg(rbf_atc_pkg::REG_INV_TWO_WIDTH, 32'h7FFF_FFFF);
        end_writes();
        random_run(150);

        // Minimum of every register.
        pick_pacing();
        write_reg(rbf_atc_pkg::REG_POS_GAIN, 32'h0);
        write_reg(rbf_atc_pkg::REG_VEL_GAIN, 32'h0);
        write_reg(rbf_atc_pkg::REG_TORQUE_SCALE, 32'h0);
        write_reg(rbf_atc_pkg::REG_ADAPT_GAIN, 32'h0);
        write_reg(rbf_atc_pkg::REG_LEAK_GAIN, 32'h8000_0000);
        write_reg(rbf_atc_pkg::REG_ERR_COEF, 32'h8000_0000);
        write_reg(rbf_atc_pkg::REG_RATE_COEF, 32'h8000_0000);
        write_reg(rbf_atc_pkg::REG_INV_TWO_WIDTH, 32'h0);
        end_writes();
        random_run(150);

        // Moderate random settings; keep leakage small so weights live on.
        for (int ph = 0; ph < 5; ph++)
        begin
            pick_pacing();
            write_reg(rbf_atc_pkg::REG_POS_GAIN,
                      $urandom_range(0, 1048576) | ($urandom & 32'h8000_0000));
            write_reg(rbf_atc_pkg::REG_VEL_GAIN, $urandom_range(0, 1048576));
            write_reg(rbf_atc_pkg::REG_TORQUE_SCALE, $urandom_range(0, 2097152));
            write_reg(rbf_atc_pkg::REG_ADAPT_GAIN, $urandom_range(0, 524288));
            write_reg(rbf_atc_pkg::REG_LEAK_GAIN, $urandom_range(0, 2000) - 1000);
            write_reg(rbf_atc_pkg::REG_ERR_COEF, $urandom_range(0, 16777216) - 8388608);
            write_reg(rbf_atc_pkg::REG_RATE_COEF, $urandom_range(0, 16777216) - 8388608);
            write_reg(rbf_atc_pkg::REG_INV_TWO_WIDTH,
                      ph == 4 ? $urandom : $urandom_range(0, 65536));
            end_writes();
            random_run(170);
        end

        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
